// ===== design/erp_pkg.sv =====
package erp_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_Q          = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W          = SINE_TABLE_BITS + 1;
    localparam int ANGLE_W         = 16;

    localparam int OFS_W       = 33;
    localparam int COORD_W     = 38;
    localparam int TRIG_W      = 18;
    localparam int PROD_W      = COORD_W + TRIG_W;
    localparam int SQ_W        = 68;
    localparam int ROOT_W      = SQ_W / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int ISQRT_LAT   = SQRT_STAGES + 2;
    localparam int ROT_LAT     = 3;
    localparam int UNIT_LAT    = 1 + ISQRT_LAT + 3 * ROT_LAT + 1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TRIG_UNITY  = 64'd65536;

    localparam logic CMD_ROTATE = 1'b0;
    localparam logic CMD_ORIENT = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [15:0]        angle_x;
        logic [15:0]        angle_y;
        logic [15:0]        angle_z;
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic signed [31:0] pivot_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic signed [31:0] result_z;
    } out_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] ay;
        logic [ANGLE_W-1:0] az;
        logic signed [31:0] pvx;
        logic signed [31:0] pvy;
        logic signed [31:0] pvz;
    } carry_t;

    typedef struct packed {
        logic                    command;
        logic signed [OFS_W-1:0] dx;
        logic signed [OFS_W-1:0] dy;
        logic signed [OFS_W-1:0] dz;
        logic [ANGLE_W-1:0]      ax;
        carry_t                  carry;
    } ctx_t;

    typedef logic [16:0] sine_rom_t [0:SINE_Q];

    // shift-subtract quotient, used only while building the table
    function automatic longint unsigned rom_quot(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = (r << 1) | ((n >> b) & 64'd1);
            if (r >= d)
            begin
                r = r - d;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    function automatic sine_rom_t sine_rom_build();
        sine_rom_t          rom;
        longint unsigned    x;
        longint unsigned    x2;
        longint unsigned    term;
        longint unsigned    r;
        longint             sum;
        for (int i = 0; i <= SINE_Q; i++)
        begin
            x    = (HALF_PI_Q30 * longint'(i)) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 12; k++)
            begin
                if (term != 0)
                begin
                    term = rom_quot((term * x2) >> 30, longint'((2 * k) * (2 * k + 1)));
                    if ((k & 1) == 1)
                        sum = sum - longint'(term);
                    else
                        sum = sum + longint'(term);
                end
            end
            if (sum < 0)
                sum = 0;
            r = (longint'(sum) + 64'd8192) >> 14;
            if (r > TRIG_UNITY)
                r = TRIG_UNITY;
            rom[i] = r[16:0];
        end
        return rom;
    endfunction

endpackage

// ===== design/erp_isqrt.sv =====
module erp_isqrt (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  erp_pkg::ctx_t                        in_ctx,
    output logic                                 out_valid,
    output logic signed [erp_pkg::COORD_W-1:0]   out_x,
    output logic signed [erp_pkg::COORD_W-1:0]   out_y,
    output logic signed [erp_pkg::COORD_W-1:0]   out_z,
    output logic [erp_pkg::ANGLE_W-1:0]          out_ax,
    output erp_pkg::carry_t                      out_carry
);

    localparam int NS = erp_pkg::SQRT_STAGES;
    localparam int SW = erp_pkg::SQ_W;
    localparam int RW = erp_pkg::ROOT_W;
    localparam int MW = erp_pkg::REM_W;
    localparam int CW = erp_pkg::COORD_W;
    localparam int OW = erp_pkg::OFS_W;

    logic          vld_reg [0:NS+1];
    erp_pkg::ctx_t ctx_reg [0:NS+1];

    logic [31:0]   pa_reg [0:2];
    logic [32:0]   pm_reg [0:2];
    logic [33:0]   pb_reg [0:2];

    logic [SW-1:0] sq_reg   [0:NS];
    logic [MW-1:0] rem_reg  [0:NS];
    logic [RW-1:0] root_reg [0:NS];

    logic [OW-1:0] mag [0:2];
    logic [SW-1:0] sum_next;

    always_comb
    begin
        mag[0] = in_ctx.dx[OW-1] ? OW'(-in_ctx.dx) : OW'(in_ctx.dx);
        mag[1] = in_ctx.dy[OW-1] ? OW'(-in_ctx.dy) : OW'(in_ctx.dy);
        mag[2] = in_ctx.dz[OW-1] ? OW'(-in_ctx.dz) : OW'(in_ctx.dz);
        sum_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            sum_next = sum_next + (SW'(pa_reg[j]) << 34) + (SW'(pm_reg[j]) << 18)
                       + SW'(pb_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= NS + 1; j++)
                vld_reg[j] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int j = 1; j <= NS + 1; j++)
                vld_reg[j] <= vld_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg[0] <= in_ctx;
        for (int j = 1; j <= NS + 1; j++)
            ctx_reg[j] <= ctx_reg[j-1];
        for (int j = 0; j < 3; j++)
        begin
            pa_reg[j] <= 32'(mag[j][32:17] * mag[j][32:17]);
            pm_reg[j] <= 33'(mag[j][32:17] * mag[j][16:0]);
            pb_reg[j] <= 34'(mag[j][16:0] * mag[j][16:0]);
        end
        sq_reg[0]   <= sum_next;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
    end

    // one root bit per stage
    for (genvar k = 0; k < NS; k++)
    begin : g_sqrt
        logic [MW+1:0] cur;
        logic [MW+1:0] trial;
        logic          ge;

        always_comb
        begin
            cur   = {rem_reg[k], sq_reg[k][SW-1 -: 2]};
            trial = (MW+2)'({root_reg[k], 2'b01});
            ge    = (cur >= trial);
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= ge ? MW'(cur - trial) : MW'(cur);
            root_reg[k+1] <= {root_reg[k][RW-2:0], ge};
            sq_reg[k+1]   <= sq_reg[k] << 2;
        end
    end

    erp_pkg::ctx_t last_ctx;

    always_comb
    begin
        last_ctx  = ctx_reg[NS+1];
        out_valid = vld_reg[NS+1];
        out_ax    = last_ctx.ax;
        out_carry = last_ctx.carry;
        if (last_ctx.command == erp_pkg::CMD_ORIENT)
        begin
            out_x = CW'(signed'({1'b0, root_reg[NS]}));
            out_y = '0;
            out_z = '0;
        end
        else
        begin
            out_x = CW'(last_ctx.dx);
            out_y = CW'(last_ctx.dy);
            out_z = CW'(last_ctx.dz);
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS+1] |-> ((MW+1)'(rem_reg[NS]) <= (MW+1)'({root_reg[NS], 1'b0})))
        else $error("isqrt remainder exceeds twice the root");

endmodule

// ===== design/erp_rot.sv =====
module erp_rot (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [erp_pkg::ANGLE_W-1:0]          angle,
    input  logic signed [erp_pkg::COORD_W-1:0]   in_a,
    input  logic signed [erp_pkg::COORD_W-1:0]   in_b,
    input  logic signed [erp_pkg::COORD_W-1:0]   in_p,
    input  erp_pkg::carry_t                      in_carry,
    output logic                                 out_valid,
    output logic signed [erp_pkg::COORD_W-1:0]   out_a,
    output logic signed [erp_pkg::COORD_W-1:0]   out_b,
    output logic signed [erp_pkg::COORD_W-1:0]   out_p,
    output erp_pkg::carry_t                      out_carry
);

    localparam int CW = erp_pkg::COORD_W;
    localparam int TW = erp_pkg::TRIG_W;
    localparam int PW = erp_pkg::PROD_W;
    localparam int AW = erp_pkg::ADDR_W;
    localparam int SB = erp_pkg::SINE_TABLE_BITS;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam erp_pkg::sine_rom_t SINE_ROM = erp_pkg::sine_rom_build();

    logic [AW-1:0] idx_lo;
    logic [AW-1:0] idx_hi;

    logic                 v1_reg, v2_reg, v3_reg;
    logic [16:0]          lo_reg, hi_reg;
    logic [1:0]           quad_reg;
    logic signed [CW-1:0] a1_reg, b1_reg, p1_reg, p2_reg, p3_reg;
    erp_pkg::carry_t      c1_reg, c2_reg, c3_reg;
    logic signed [PW-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic signed [CW-1:0] oa_reg, ob_reg;

    logic signed [TW-1:0] s_val, c_val, lo_s, hi_s;
    logic signed [PW:0]   sum_a, sum_b;

    assign idx_lo = AW'(angle[13 -: SB]);
    assign idx_hi = AW'(erp_pkg::SINE_Q) - idx_lo;

    always_comb
    begin
        lo_s = TW'(signed'({1'b0, lo_reg}));
        hi_s = TW'(signed'({1'b0, hi_reg}));
        unique case (quad_reg)
            QUAD_0:
            begin
                s_val = lo_s;
                c_val = hi_s;
            end
            QUAD_1:
            begin
                s_val = hi_s;
                c_val = -lo_s;
            end
            QUAD_2:
            begin
                s_val = -lo_s;
                c_val = -hi_s;
            end
            QUAD_3:
            begin
                s_val = -hi_s;
                c_val = lo_s;
            end
            default:
            begin
                s_val = '0;
                c_val = '0;
            end
        endcase
        sum_a = (PW+1)'(ac_reg) - (PW+1)'(bs_reg) + (PW+1)'(32768);
        sum_b = (PW+1)'(as_reg) + (PW+1)'(bc_reg) + (PW+1)'(32768);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= SINE_ROM[idx_lo];
        hi_reg   <= SINE_ROM[idx_hi];
        quad_reg <= angle[15:14];
        a1_reg   <= in_a;
        b1_reg   <= in_b;
        p1_reg   <= in_p;
        c1_reg   <= in_carry;

        ac_reg <= PW'(a1_reg * c_val);
        bs_reg <= PW'(b1_reg * s_val);
        as_reg <= PW'(a1_reg * s_val);
        bc_reg <= PW'(b1_reg * c_val);
        p2_reg <= p1_reg;
        c2_reg <= c1_reg;

        oa_reg <= CW'(sum_a >>> 16);
        ob_reg <= CW'(sum_b >>> 16);
        p3_reg <= p2_reg;
        c3_reg <= c2_reg;
    end

    assign out_valid = v3_reg;
    assign out_a     = oa_reg;
    assign out_b     = ob_reg;
    assign out_p     = p3_reg;
    assign out_carry = c3_reg;

endmodule

// ===== design/euler_rotate_about_pivot_unit.sv =====
// Rotates a Q16.16 point about a pivot by three binary angles (about z, then y, then x),
// or in orient mode first replaces the offset by (length,0,0). A new item may start in
// every cycle and busy never rises. Each item's result appears with done once it has
// passed the offset register, the two squaring stages and the 34-stage square-root
// pipeline, three 3-stage rotation units and the saturation register.
// Results arrive in order and are shown for one cycle only, so the receiver
// must capture each one when done is high.
module euler_rotate_about_pivot_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  erp_pkg::in_t   item,
    output logic           busy,
    output logic           done,
    output erp_pkg::out_t  result
);

    localparam int CW  = erp_pkg::COORD_W;
    localparam int OW  = erp_pkg::OFS_W;
    localparam int LAT = erp_pkg::UNIT_LAT;

    function automatic logic signed [31:0] sat32(input logic signed [CW:0] v);
        if (v > (CW+1)'(32'sh7FFFFFFF))
            return 32'sh7FFFFFFF;
        else if (v < -(CW+1)'(33'sh080000000))
            return 32'sh80000000;
        else
            return 32'(v);
    endfunction

    logic          s0_valid_reg;
    erp_pkg::ctx_t s0_ctx_reg;
    erp_pkg::ctx_t s0_ctx_next;

    always_comb
    begin
        s0_ctx_next.command   = item.command;
        s0_ctx_next.dx        = OW'(item.point_x) - OW'(item.pivot_x);
        s0_ctx_next.dy        = OW'(item.point_y) - OW'(item.pivot_y);
        s0_ctx_next.dz        = OW'(item.point_z) - OW'(item.pivot_z);
        s0_ctx_next.ax        = item.angle_x;
        s0_ctx_next.carry.ay  = item.angle_y;
        s0_ctx_next.carry.az  = item.angle_z;
        s0_ctx_next.carry.pvx = item.pivot_x;
        s0_ctx_next.carry.pvy = item.pivot_y;
        s0_ctx_next.carry.pvz = item.pivot_z;
    end

    logic                 q_valid;
    logic signed [CW-1:0] q_x, q_y, q_z;
    logic [15:0]          q_ax;
    erp_pkg::carry_t      q_carry;

    erp_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_ctx    (s0_ctx_reg),
        .out_valid (q_valid),
        .out_x     (q_x),
        .out_y     (q_y),
        .out_z     (q_z),
        .out_ax    (q_ax),
        .out_carry (q_carry)
    );

    logic                 r1_valid, r2_valid, r3_valid;
    logic signed [CW-1:0] r1_x, r1_y, r1_z;
    logic signed [CW-1:0] r2_x, r2_z, r2_y;
    logic signed [CW-1:0] r3_z, r3_y, r3_x;
    erp_pkg::carry_t      r1_carry, r2_carry, r3_carry;

    erp_rot u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .angle     (q_ax),
        .in_a      (q_x),
        .in_b      (q_y),
        .in_p      (q_z),
        .in_carry  (q_carry),
        .out_valid (r1_valid),
        .out_a     (r1_x),
        .out_b     (r1_y),
        .out_p     (r1_z),
        .out_carry (r1_carry)
    );

    erp_rot u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r1_valid),
        .angle     (r1_carry.ay),
        .in_a      (r1_x),
        .in_b      (r1_z),
        .in_p      (r1_y),
        .in_carry  (r1_carry),
        .out_valid (r2_valid),
        .out_a     (r2_x),
        .out_b     (r2_z),
        .out_p     (r2_y),
        .out_carry (r2_carry)
    );

    // x axis: opposite sign convention, z takes the role of the first coordinate
    erp_rot u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r2_valid),
        .angle     (r2_carry.az),
        .in_a      (r2_z),
        .in_b      (r2_y),
        .in_p      (r2_x),
        .in_carry  (r2_carry),
        .out_valid (r3_valid),
        .out_a     (r3_z),
        .out_b     (r3_y),
        .out_p     (r3_x),
        .out_carry (r3_carry)
    );

    logic          done_reg;
    erp_pkg::out_t result_reg;
    erp_pkg::out_t result_next;

    always_comb
    begin
        result_next.result_x = sat32((CW+1)'(r3_x) + (CW+1)'(r3_carry.pvx));
        result_next.result_y = sat32((CW+1)'(r3_y) + (CW+1)'(r3_carry.pvy));
        result_next.result_z = sat32((CW+1)'(r3_z) + (CW+1)'(r3_carry.pvz));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start;
            done_reg     <= r3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_ctx_reg <= s0_ctx_next;
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("item lost in pipeline");

    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without item");

    a_orient_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && item.command == erp_pkg::CMD_ORIENT && item.point_x == item.pivot_x
         && item.point_y == item.pivot_y && item.point_z == item.pivot_z)
        |-> ##LAT (result.result_x == $past(item.pivot_x, LAT)))
        else $error("orient on pivot did not return pivot");

endmodule
